@@ sv/vn_pkg.sv @@
package vn_pkg;

  localparam int CompW  = 16;
  localparam int SumW   = 32;
  localparam int RootW  = 16;
  localparam int RemW   = RootW + 4;
  localparam int QuotW  = 15;
  localparam int DRemW  = CompW + 1;
  localparam int Lanes  = 3;

  // Data that rides along with the square root chain.
  typedef struct packed {
    logic [Lanes-1:0]            neg;
    logic [Lanes-1:0][CompW-1:0] mag;
  } vn_side_t;

  // Working state of one divider lane.
  typedef struct packed {
    logic [DRemW-1:0] rem;
    logic [QuotW-1:0] quot;
    logic [QuotW-1:0] bits;
  } vn_lane_t;

  // Control and shared data that ride along with the divider chain.
  typedef struct packed {
    logic             vld;
    logic [Lanes-1:0] neg;
    logic [RootW-1:0] len;
  } vn_dctl_t;

endpackage

@@ sv/vn_square.sv @@
module vn_square import vn_pkg::*; (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        vld_i,
  input  logic [Lanes-1:0][CompW-1:0] comp_i,
  output logic                        vld_o,
  output logic [SumW-1:0]             sum_o,
  output vn_side_t                    side_o
);

  logic [2:0]              vld_q;
  vn_side_t                side_a_q, side_b_q, side_c_q;
  logic [Lanes-1:0][SumW-1:0] sq_q;
  logic [SumW-1:0]         sum_q;
  vn_side_t                side_a_d;

  always_comb begin
    for (int l = 0; l < Lanes; l++) begin
      side_a_d.neg[l] = comp_i[l][CompW-1];
      side_a_d.mag[l] = comp_i[l][CompW-1] ? (~comp_i[l] + 1'b1) : comp_i[l];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[1:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_a_q <= side_a_d;
      for (int l = 0; l < Lanes; l++) begin
        sq_q[l] <= SumW'(side_a_q.mag[l]) * SumW'(side_a_q.mag[l]);
      end
      side_b_q <= side_a_q;
      // The sum is at most 3 * 2^30 and fits.
      sum_q    <= sq_q[0] + sq_q[1] + sq_q[2];
      side_c_q <= side_b_q;
    end
  end

  assign vld_o  = vld_q[2];
  assign sum_o  = sum_q;
  assign side_o = side_c_q;

endmodule

@@ sv/vn_sqrt_cell.sv @@
module vn_sqrt_cell import vn_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             vld_i,
  input  logic [SumW-1:0]  rad_i,
  input  logic [RemW-1:0]  rem_i,
  input  logic [RootW-1:0] root_i,
  input  vn_side_t         side_i,
  output logic             vld_o,
  output logic [SumW-1:0]  rad_o,
  output logic [RemW-1:0]  rem_o,
  output logic [RootW-1:0] root_o,
  output vn_side_t         side_o
);

  logic             vld_q;
  logic [SumW-1:0]  rad_q;
  logic [RemW-1:0]  rem_q, rem_d, cur, trial;
  logic [RootW-1:0] root_q, root_d;
  vn_side_t         side_q;

  // One root bit per cell: bring down two radicand bits and try root*4+1.
  always_comb begin
    cur   = {rem_i[RemW-3:0], rad_i[SumW-1:SumW-2]};
    trial = RemW'({root_i, 2'b01});
    if (cur >= trial) begin
      rem_d  = cur - trial;
      root_d = {root_i[RootW-2:0], 1'b1};
    end else begin
      rem_d  = cur;
      root_d = {root_i[RootW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rad_q  <= {rad_i[SumW-3:0], 2'b00};
      rem_q  <= rem_d;
      root_q <= root_d;
      side_q <= side_i;
    end
  end

  assign vld_o  = vld_q;
  assign rad_o  = rad_q;
  assign rem_o  = rem_q;
  assign root_o = root_q;
  assign side_o = side_q;

endmodule

@@ sv/vn_div_cell.sv @@
module vn_div_cell import vn_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  vn_dctl_t             ctl_i,
  input  vn_lane_t [Lanes-1:0] lane_i,
  output vn_dctl_t             ctl_o,
  output vn_lane_t [Lanes-1:0] lane_o
);

  logic                 vld_q;
  vn_dctl_t             ctl_q;
  vn_lane_t [Lanes-1:0] lane_q, lane_d;
  logic [DRemW-1:0]     cur [Lanes];

  // One quotient bit per lane per cell, restoring division by the length.
  always_comb begin
    for (int l = 0; l < Lanes; l++) begin
      cur[l] = {lane_i[l].rem[DRemW-2:0], lane_i[l].bits[QuotW-1]};
      lane_d[l].bits = {lane_i[l].bits[QuotW-2:0], 1'b0};
      if (cur[l] >= DRemW'(ctl_i.len)) begin
        lane_d[l].rem  = cur[l] - DRemW'(ctl_i.len);
        lane_d[l].quot = {lane_i[l].quot[QuotW-2:0], 1'b1};
      end else begin
        lane_d[l].rem  = cur[l];
        lane_d[l].quot = {lane_i[l].quot[QuotW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= ctl_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ctl_q  <= ctl_i;
      lane_q <= lane_d;
    end
  end

  always_comb begin
    ctl_o     = ctl_q;
    ctl_o.vld = vld_q;
  end

  assign lane_o = lane_q;

endmodule

@@ sv/vector3_normalize.sv @@
// Channel  | Dir | tdata fields (low bit up)                     | tuser
// s_axis   | in  | comp_x_in, comp_y_in, comp_z_in (48 bits)     | -
// m_axis   | out | unit_x, unit_y, unit_z, vec_length (64 bits)  | zero_length
//
// One item per cycle is accepted while the output is not held; each passes from acceptance
// to output through three square and sum stages, one square root cell per root bit,
// one divider cell per quotient bit and an output register. Reset clears valid bits only.
// The whole chain advances together; it holds while the output item waits.
module vector3_normalize import vn_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // comp_x_in, comp_y_in, comp_z_in
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // unit_x, unit_y, unit_z, vec_length
  output logic        m_axis_tuser    // zero_length
);

  logic en;
  logic out_vld_q;
  logic [63:0] out_data_q;
  logic out_zero_q;

  assign en = !out_vld_q || m_axis_tready;
  assign s_axis_tready = en;

  logic [Lanes-1:0][CompW-1:0] comp;
  assign comp[0] = s_axis_tdata[15:0];
  assign comp[1] = s_axis_tdata[31:16];
  assign comp[2] = s_axis_tdata[47:32];

  logic            sq_vld;
  logic [SumW-1:0] sq_sum;
  vn_side_t        sq_side;

  vn_square u_square (
    .clk_i(clk_i), .rst_ni(rst_ni), .en_i(en),
    .vld_i(s_axis_tvalid && en), .comp_i(comp),
    .vld_o(sq_vld), .sum_o(sq_sum), .side_o(sq_side)
  );

  logic             s_vld  [RootW+1];
  logic [SumW-1:0]  s_rad  [RootW+1];
  logic [RemW-1:0]  s_rem  [RootW+1];
  logic [RootW-1:0] s_root [RootW+1];
  vn_side_t         s_side [RootW+1];

  assign s_vld[0]  = sq_vld;
  assign s_rad[0]  = sq_sum;
  assign s_rem[0]  = '0;
  assign s_root[0] = '0;
  assign s_side[0] = sq_side;

  for (genvar i = 0; i < RootW; i++) begin : g_sqrt
    vn_sqrt_cell u_cell (
      .clk_i(clk_i), .rst_ni(rst_ni), .en_i(en),
      .vld_i(s_vld[i]), .rad_i(s_rad[i]), .rem_i(s_rem[i]),
      .root_i(s_root[i]), .side_i(s_side[i]),
      .vld_o(s_vld[i+1]), .rad_o(s_rad[i+1]), .rem_o(s_rem[i+1]),
      .root_o(s_root[i+1]), .side_o(s_side[i+1])
    );
  end

  vn_dctl_t             d_ctl  [QuotW+1];
  vn_lane_t [Lanes-1:0] d_lane [QuotW+1];

  // Dividend is mag * 2^14; its top part mag >> 1 is already below the length.
  always_comb begin
    d_ctl[0].vld = s_vld[RootW];
    d_ctl[0].neg = s_side[RootW].neg;
    d_ctl[0].len = s_root[RootW];
    for (int l = 0; l < Lanes; l++) begin
      d_lane[0][l].rem  = DRemW'(s_side[RootW].mag[l][CompW-1:1]);
      d_lane[0][l].quot = '0;
      d_lane[0][l].bits = {s_side[RootW].mag[l][0], {(QuotW-1){1'b0}}};
    end
  end

  for (genvar i = 0; i < QuotW; i++) begin : g_div
    vn_div_cell u_cell (
      .clk_i(clk_i), .rst_ni(rst_ni), .en_i(en),
      .ctl_i(d_ctl[i]), .lane_i(d_lane[i]),
      .ctl_o(d_ctl[i+1]), .lane_o(d_lane[i+1])
    );
  end

  logic [63:0] out_data_d;
  logic        zero_d;

  always_comb begin
    zero_d = (d_ctl[QuotW].len == '0);
    for (int l = 0; l < Lanes; l++) begin
      if (zero_d) begin
        out_data_d[16*l +: 16] = '0;
      end else if (d_ctl[QuotW].neg[l]) begin
        out_data_d[16*l +: 16] = 16'(~{1'b0, d_lane[QuotW][l].quot} + 1'b1);
      end else begin
        out_data_d[16*l +: 16] = {1'b0, d_lane[QuotW][l].quot};
      end
    end
    out_data_d[63:48] = d_ctl[QuotW].len;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= d_ctl[QuotW].vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_data_q <= out_data_d;
      out_zero_q <= zero_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_zero_q;

endmodule
